// ===== hw/rtl/wmed_pkg.sv =====
`default_nettype none
package wmed_pkg;

  localparam int unsigned DefMaxHeight   = 128;
  localparam int unsigned DefMaxWidth    = 128;
  localparam int unsigned DefMaxChannels = 4;
  localparam int unsigned DefMaxWindow   = 7;

  localparam int unsigned SampleW = 8;
  localparam int unsigned RegIdxW = 3;

  localparam logic [RegIdxW-1:0] RegHeight  = 3'd0;
  localparam logic [RegIdxW-1:0] RegWidth   = 3'd1;
  localparam logic [RegIdxW-1:0] RegChans   = 3'd2;
  localparam logic [RegIdxW-1:0] RegWindow  = 3'd3;
  localparam logic [RegIdxW-1:0] RegBorder  = 3'd4;
  localparam logic [RegIdxW-1:0] RegFill    = 3'd5;

  localparam logic [1:0] BorderConst     = 2'd0;
  localparam logic [1:0] BorderReflect   = 2'd1;
  localparam logic [1:0] BorderReplicate = 2'd2;
  localparam logic [1:0] BorderWrap      = 2'd3;

  typedef enum logic [2:0] {
    StIdle,
    StAddr,
    StRead,
    StLoad,
    StCount,
    StDone
  } state_e;

  // Control from the sequencer to the bit-serial rank counter.
  typedef struct packed {
    logic clear;
    logic load;
    logic shift;
  } rank_ctrl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/wmed_rank.sv =====
`default_nettype none
// Bit-serial median select: finds the sample of rank n/2 by deciding the
// result one bit per cycle while shift is asserted, MSB first, over the stored window samples.
module wmed_rank
  import wmed_pkg::*;
#(
  parameter int unsigned NumSamples = 49
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire rank_ctrl_t         ctrl_i,
  input  wire logic [5:0]         load_idx_i,
  input  wire logic [SampleW-1:0] load_val_i,
  input  wire logic [5:0]         count_i,
  output logic [SampleW-1:0]      median_o
);
  localparam int unsigned CntW = $clog2(NumSamples + 1);

  logic [SampleW-1:0] samp_q [NumSamples];
  logic [NumSamples-1:0] act_q, act_d;
  logic [SampleW-1:0] res_q, res_d;
  logic [CntW-1:0] rank_q, rank_d;
  logic [NumSamples-1:0] zero_bits;
  logic [CntW-1:0] zeros;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      samp_q[load_idx_i[CntW-1:0]] <= load_val_i;
    end else if (ctrl_i.shift) begin
      for (int i = 0; i < NumSamples; i++) begin
        samp_q[i] <= {samp_q[i][SampleW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    zero_bits = '0;
    for (int i = 0; i < NumSamples; i++) begin
      zero_bits[i] = act_q[i] & ~samp_q[i][SampleW-1];
    end
    zeros = CntW'($countones(zero_bits));
  end

  always_comb begin
    act_d  = act_q;
    res_d  = res_q;
    rank_d = rank_q;
    if (ctrl_i.clear) begin
      for (int i = 0; i < NumSamples; i++) begin
        act_d[i] = (6'(i) < count_i);
      end
      rank_d = CntW'(count_i >> 1);
      res_d  = '0;
    end else if (ctrl_i.shift) begin
      if (rank_q < zeros) begin
        act_d = act_q & zero_bits;
        res_d = {res_q[SampleW-2:0], 1'b0};
      end else begin
        act_d  = act_q & ~zero_bits;
        rank_d = rank_q - zeros;
        res_d  = {res_q[SampleW-2:0], 1'b1};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= '0;
      res_q  <= '0;
      rank_q <= '0;
    end else begin
      act_q  <= act_d;
      res_q  <= res_d;
      rank_q <= rank_d;
    end
  end

  assign median_o = res_q;
endmodule
`default_nettype wire

// ===== hw/rtl/window_median_with_border_modes_unit.sv =====
`default_nettype none
// Channel   | Direction | Handshake           | Payload
// request   | in        | start_i / busy_o    | action_i row_i col_i chan_i pixel_in_i
// result    | out       | done_o (one cycle)  | out_row_o out_col_o out_chan_o median_o
// config    | in        | cfg_valid_i/ready_o | cfg_index_i cfg_data_i
//
// A write is taken in the cycle it is offered and never raises busy_o, so writes
// can follow back to back. A query keeps busy_o high while the sequencer walks a window
// of side K: each window sample takes an address, a store read and a load state, then
// the rank counter runs its clear and bit states and done_o rises in the last busy
// cycle. Reset clears the control state and sets the configuration registers to their
// defaults; the store holds no defined data until written. The receiver cannot stall.
module window_median_with_border_modes_unit
  import wmed_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  output logic              busy_o,
  input  wire logic         action_i,
  input  wire logic [6:0]   row_i,
  input  wire logic [6:0]   col_i,
  input  wire logic [1:0]   chan_i,
  input  wire logic [7:0]   pixel_in_i,
  output logic              done_o,
  output logic [6:0]        out_row_o,
  output logic [6:0]        out_col_o,
  output logic [1:0]        out_chan_o,
  output logic [7:0]        median_o,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [2:0]   cfg_index_i,
  input  wire logic [7:0]   cfg_data_i
);
  localparam int unsigned MaxHeight   = DefMaxHeight;
  localparam int unsigned MaxWidth    = DefMaxWidth;
  localparam int unsigned MaxChannels = DefMaxChannels;
  localparam int unsigned MaxWindow   = DefMaxWindow;
  localparam int unsigned RowW  = $clog2(MaxHeight) > 0 ? $clog2(MaxHeight) : 1;
  localparam int unsigned ColW  = $clog2(MaxWidth) > 0 ? $clog2(MaxWidth) : 1;
  localparam int unsigned ChW   = $clog2(MaxChannels) > 0 ? $clog2(MaxChannels) : 1;
  localparam int unsigned AddrW = RowW + ColW + ChW;
  localparam int unsigned Depth = 1 << AddrW;
  localparam int unsigned WinCap = ((MaxWindow - 1) | 1);
  localparam int unsigned NumSamples = WinCap * WinCap;
  localparam int signed   CoordW = 14;

  // Configuration registers.
  logic [7:0] height_q, width_q, fill_q;
  logic [2:0] chans_q, window_q;
  logic [1:0] border_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q <= 8'd128;
      width_q  <= 8'd128;
      chans_q  <= 3'd1;
      window_q <= 3'd3;
      border_q <= BorderConst;
      fill_q   <= 8'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegHeight: height_q <= cfg_data_i;
        RegWidth:  width_q  <= cfg_data_i;
        RegChans:  chans_q  <= cfg_data_i[2:0];
        RegWindow: window_q <= cfg_data_i[2:0];
        RegBorder: border_q <= cfg_data_i[1:0];
        RegFill:   fill_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end
  assign cfg_ready_o = 1'b1;

  // Effective geometry.
  logic signed [CoordW-1:0] h_eff, w_eff;
  logic [2:0] nc_eff;
  logic [3:0] k_eff;
  logic [2:0] rad;
  always_comb begin
    h_eff = (height_q == 8'd0) ? CoordW'(1) :
            (32'(height_q) > MaxHeight) ? CoordW'(MaxHeight) : CoordW'(height_q);
    w_eff = (width_q == 8'd0) ? CoordW'(1) :
            (32'(width_q) > MaxWidth) ? CoordW'(MaxWidth) : CoordW'(width_q);
    nc_eff = (chans_q == 3'd0) ? 3'd1 :
             (32'(chans_q) > MaxChannels) ? 3'(MaxChannels) : chans_q;
    k_eff = {1'b0, window_q | 3'd1};
    if (k_eff < 4'd3) k_eff = 4'd3;
    if (32'(k_eff) > WinCap) k_eff = 4'(WinCap);
    rad = k_eff[3:1];
  end

  // Request registers.
  logic [6:0] row_q, col_q;
  logic [1:0] chan_q;
  logic       act_q;
  logic       in_range;
  assign in_range = (CoordW'(row_i) < h_eff) && (CoordW'(col_i) < w_eff) &&
                    ({1'b0, chan_i} < nc_eff);

  state_e state_q, state_d;
  logic signed [4:0] dy_q, dy_d, dx_q, dx_d;
  logic [5:0] n_q, n_d;
  logic [3:0] bit_q, bit_d;
  logic       use_fill_q;

  // Neighbor coordinate mapping.
  function automatic logic signed [CoordW-1:0] map_axis(
    input logic signed [CoordW-1:0] i,
    input logic signed [CoordW-1:0] n,
    input logic [1:0] mode
  );
    logic signed [CoordW-1:0] m;
    begin
      m = i;
      case (mode)
        BorderReflect: begin
          if (n == CoordW'(1)) m = '0;
          else begin
            if (i < 0) m = -i - CoordW'(1);
            else if (i >= n) m = (n <<< 1) - i - CoordW'(1);
            if (m < 0) m = '0;
            if (m > n - CoordW'(1)) m = n - CoordW'(1);
          end
        end
        BorderWrap: begin
          // The window reaches at most three steps past an edge, so a few
          // folds cover even an axis narrower than the radius.
          if (i < 0) m = i + n;
          else if (i >= n) m = i - n;
          while_fix: begin
            if (m < 0) m = m + n;
            if (m >= n) m = m - n;
          end
          if (m < 0) m = m + n;
          if (m >= n) m = m - n;
          if (m < 0) m = m + n;
          if (m >= n) m = m - n;
        end
        default: begin
          if (m < 0) m = '0;
          if (m > n - CoordW'(1)) m = n - CoordW'(1);
        end
      endcase
      return m;
    end
  endfunction

  logic signed [CoordW-1:0] r_abs, c_abs, r_map, c_map;
  logic out_img;
  always_comb begin
    r_abs = CoordW'(row_q) + CoordW'(dy_q);
    c_abs = CoordW'(col_q) + CoordW'(dx_q);
    out_img = (r_abs < 0) || (r_abs >= h_eff) || (c_abs < 0) || (c_abs >= w_eff);
    r_map = map_axis(r_abs, h_eff, border_q);
    c_map = map_axis(c_abs, w_eff, border_q);
  end

  // Sample store.
  logic [7:0] mem [Depth];
  logic [AddrW-1:0] addr_q;
  logic [7:0] rd_q;
  logic       wr_en;
  assign wr_en = (state_q == StIdle) && start_i && !action_i && in_range;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[{row_i[RowW-1:0], col_i[ColW-1:0], chan_i[ChW-1:0]}] <= pixel_in_i;
    end
    rd_q <= mem[addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start_i) begin
      row_q <= row_i;
      col_q <= col_i;
      chan_q <= chan_i;
      act_q <= action_i;
    end
    if (state_q == StAddr) begin
      addr_q <= {r_map[RowW-1:0], c_map[ColW-1:0], chan_q[ChW-1:0]};
      use_fill_q <= (border_q == BorderConst) && out_img;
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    dy_d = dy_q;
    dx_d = dx_q;
    n_d = n_q;
    bit_d = bit_q;
    case (state_q)
      StIdle: if (start_i && action_i && in_range) begin
        state_d = StAddr;
        dy_d = -$signed({2'b0, rad});
        dx_d = -$signed({2'b0, rad});
        n_d = '0;
      end
      StAddr: state_d = StRead;
      StRead: state_d = StLoad;
      StLoad: begin
        n_d = n_q + 6'd1;
        if (dx_q == $signed({2'b0, rad})) begin
          dx_d = -$signed({2'b0, rad});
          dy_d = dy_q + 5'sd1;
        end else begin
          dx_d = dx_q + 5'sd1;
        end
        if (dx_q == $signed({2'b0, rad}) && dy_q == $signed({2'b0, rad})) begin
          state_d = StCount;
          bit_d = 4'd0;
        end else begin
          state_d = StAddr;
        end
      end
      StCount: begin
        bit_d = bit_q + 4'd1;
        if (bit_q == 4'(SampleW)) state_d = StDone;
      end
      StDone: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      dy_q <= '0;
      dx_q <= '0;
      n_q <= '0;
      bit_q <= '0;
    end else begin
      state_q <= state_d;
      dy_q <= dy_d;
      dx_q <= dx_d;
      n_q <= n_d;
      bit_q <= bit_d;
    end
  end

  // Outputs and rank control.
  rank_ctrl_t rctl;
  always_comb begin
    rctl.load  = (state_q == StLoad);
    rctl.clear = (state_q == StCount) && (bit_q == 4'd0);
    rctl.shift = (state_q == StCount) && (bit_q != 4'd0);
    busy_o = (state_q != StIdle);
    done_o = (state_q == StDone);
  end

  logic [7:0] rank_med;
  wmed_rank #(.NumSamples(NumSamples)) u_rank (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (rctl),
    .load_idx_i (n_q),
    .load_val_i (use_fill_q ? fill_q : rd_q),
    .count_i    (n_q),
    .median_o   (rank_med)
  );

  assign out_row_o  = row_q;
  assign out_col_o  = col_q;
  assign out_chan_o = chan_q;
  assign median_o   = rank_med;

  // Checks.
  a_done_after_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q) == StCount) else $error("done without count");
  a_done_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> act_q) else $error("result for a write");
  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result repeated");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= 6'(NumSamples)) else $error("count overflow");
endmodule
`default_nettype wire

// ===== tb/window_median_with_border_modes_unit_tb.sv =====
`default_nettype none
module window_median_with_border_modes_unit_tb;
  import wmed_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StoreDepth = DefMaxHeight * DefMaxWidth * DefMaxChannels;
  localparam int unsigned StallLimit = 5000;

  typedef struct {
    logic [6:0] row;
    logic [6:0] col;
    logic [1:0] chan;
    logic [7:0] median;
  } median_res_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start_i = 1'b0;
  logic       busy_o;
  logic       action_i = 1'b0;
  logic [6:0] row_i = '0;
  logic [6:0] col_i = '0;
  logic [1:0] chan_i = '0;
  logic [7:0] pixel_in_i = '0;
  logic       done_o;
  logic [6:0] out_row_o;
  logic [6:0] out_col_o;
  logic [1:0] out_chan_o;
  logic [7:0] median_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [7:0] cfg_data_i = '0;

  window_median_with_border_modes_unit dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .action_i, .row_i, .col_i, .chan_i, .pixel_in_i,
    .done_o, .out_row_o, .out_col_o, .out_chan_o, .median_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  // Testbench copy of the image, the registers and the outstanding medians.
  logic [7:0]  img_mem [StoreDepth];
  bit          img_written [StoreDepth];
  int          reg_height = 128, reg_width = 128, reg_chans = 1;
  int          reg_window = 3, reg_fill = 0;
  logic [1:0]  reg_border = BorderConst;
  median_res_t pending_medians[$];
  int          errors = 0;
  int          n_items = 0, n_queries = 0, n_medians = 0, n_cfg = 0;
  int          stall_cnt = 0;
  bit          quiet = 1'b0;

  function automatic int clamp(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic int eff_height();
    return clamp(reg_height, 1, DefMaxHeight);
  endfunction

  function automatic int eff_width();
    return clamp(reg_width, 1, DefMaxWidth);
  endfunction

  function automatic int eff_chans();
    return clamp(reg_chans, 1, DefMaxChannels);
  endfunction

  function automatic int fold_index(int i, int n);
    int m;
    case (reg_border)
      BorderReflect: begin
        if (n == 1) return 0;
        m = (i < 0) ? -i - 1 : (i >= n) ? 2 * n - i - 1 : i;
        return clamp(m, 0, n - 1);
      end
      BorderWrap: begin
        m = i % n;
        return (m < 0) ? m + n : m;
      end
      default: return clamp(i, 0, n - 1);
    endcase
  endfunction

  function automatic int store_index(int r, int c, int ch);
    return (r * DefMaxWidth + c) * DefMaxChannels + ch;
  endfunction

  // Returns 0 when the window would touch a sample that was never written.
  function automatic bit window_median(input int r, input int c, input int ch,
                                       output logic [7:0] med);
    int h, w, k, rad, n, rr, cc, a, j;
    logic [7:0] win [49];
    logic [7:0] v;
    h = eff_height();
    w = eff_width();
    k = reg_window | 1;
    if (k < 3) k = 3;
    if (k > ((DefMaxWindow - 1) | 1)) k = (DefMaxWindow - 1) | 1;
    rad = k / 2;
    n = 0;
    med = '0;
    for (int dy = -rad; dy <= rad; dy++) begin
      for (int dx = -rad; dx <= rad; dx++) begin
        rr = r + dy;
        cc = c + dx;
        if (reg_border == BorderConst && (rr < 0 || rr >= h || cc < 0 || cc >= w)) begin
          v = reg_fill[7:0];
        end else begin
          a = store_index(fold_index(rr, h), fold_index(cc, w), ch);
          if (!img_written[a]) return 1'b0;
          v = img_mem[a];
        end
        j = n;
        while (j > 0 && win[j-1] > v) begin
          win[j] = win[j-1];
          j--;
        end
        win[j] = v;
        n++;
      end
    end
    med = win[n/2];
    return 1'b1;
  endfunction

  task automatic send_request(bit act, int r, int c, int ch, int px);
    logic [7:0] med;
    median_res_t res;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    start_i    <= 1'b1;
    action_i   <= act;
    row_i      <= r[6:0];
    col_i      <= c[6:0];
    chan_i     <= ch[1:0];
    pixel_in_i <= px[7:0];
    do @(posedge clk_i); while (busy_o);
    n_items++;
    if (r < eff_height() && c < eff_width() && ch < eff_chans()) begin
      if (!act) begin
        img_mem[store_index(r, c, ch)]     = px[7:0];
        img_written[store_index(r, c, ch)] = 1'b1;
      end else begin
        void'(window_median(r, c, ch, med));
        res.row = r[6:0];
        res.col = c[6:0];
        res.chan = ch[1:0];
        res.median = med;
        pending_medians = {pending_medians, res};
        n_queries++;
      end
    end
  endtask

  // A query is only sent when its whole window has been written.
  task automatic query_or_write(int r, int c, int ch);
    logic [7:0] med;
    if (window_median(r, c, ch, med)) send_request(1'b1, r, c, ch, $urandom_range(0, 255));
    else send_request(1'b0, r, c, ch, $urandom_range(0, 255));
  endtask

  task automatic wait_idle();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_medians.size() != 0 || busy_o);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, int val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val[7:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    n_cfg++;
    case (idx)
      RegHeight: reg_height = val & 8'hff;
      RegWidth:  reg_width  = val & 8'hff;
      RegChans:  reg_chans  = val & 3'h7;
      RegWindow: reg_window = val & 3'h7;
      RegBorder: reg_border = val[1:0];
      RegFill:   reg_fill   = val & 8'hff;
      default: ;
    endcase
  endtask

  task automatic set_image(int h, int w, int ch, int win, logic [1:0] mode, int fill);
    wait_idle();
    write_reg(RegHeight, h);
    write_reg(RegWidth, w);
    write_reg(RegChans, ch);
    write_reg(RegWindow, win);
    write_reg(RegBorder, int'(mode));
    write_reg(RegFill, fill);
  endtask

  task automatic fill_image();
    for (int r = 0; r < eff_height(); r++)
      for (int c = 0; c < eff_width(); c++)
        for (int ch = 0; ch < eff_chans(); ch++)
          send_request(1'b0, r, c, ch, $urandom_range(0, 255));
  endtask

  // One-row and one-column images, clamped sizes, forced window sizes,
  // ignored out-of-image items, and every border mode at a corner.
  task automatic test_special_cases();
    set_image(0, 3, 0, 0, BorderReflect, 0);
    send_request(1'b0, 0, 0, 0, 0);
    send_request(1'b0, 0, 1, 0, 255);
    send_request(1'b0, 0, 2, 0, 17);
    send_request(1'b0, 1, 0, 0, 99);
    send_request(1'b0, 0, 0, 1, 99);
    for (int c = 0; c < 3; c++) send_request(1'b1, 0, c, 0, 0);
    send_request(1'b1, 0, 5, 0, 0);
    send_request(1'b1, 3, 0, 0, 0);
    send_request(1'b1, 0, 0, 3, 0);
    for (int m = 0; m < 4; m++) begin
      set_image(1, 3, 1, 7, m[1:0], (m == 0) ? 255 : 0);
      send_request(1'b1, 0, 0, 0, 0);
      send_request(1'b1, 0, 2, 0, 0);
    end
    set_image(1, 1, 7, 6, BorderReflect, 0);
    send_request(1'b1, 0, 0, 0, 0);
    set_image(200, 200, 4, 4, BorderReplicate, 0);
    // The replicated corner window covers the last three rows and columns.
    for (int r = 125; r < 128; r++)
      for (int c = 125; c < 128; c++)
        send_request(1'b0, r, c, 3, $urandom_range(0, 255));
    send_request(1'b1, 127, 127, 3, 0);
  endtask

  // Full-size image with only the four corners written, queried near them in every border mode; wrap joins them.
  task automatic test_full_size_corners();
    int r, c;
    set_image(128, 128, 4, 5, BorderWrap, 0);
    for (int i = 0; i < 8; i++)
      for (int j = 0; j < 8; j++)
        send_request(1'b0, (i < 4) ? i : 120 + i, (j < 4) ? j : 120 + j, 3,
                     $urandom_range(0, 255));
    for (int m = 0; m < 4; m++) begin
      set_image(128, 128, 4, $urandom_range(3, 5), m[1:0], $urandom_range(0, 255));
      repeat (12) begin
        r = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(124, 127);
        c = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(124, 127);
        query_or_write(r, c, 3);
      end
    end
  endtask

  task automatic test_random_images(int target);
    int kind;
    while (n_items < target) begin
      set_image($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(0, 7),
                $urandom_range(0, 7), 2'($urandom_range(0, 3)), $urandom_range(0, 255));
      fill_image();
      repeat (60) begin
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
          send_request(1'($urandom_range(0, 1)), $urandom_range(0, 127),
                       $urandom_range(0, 127), $urandom_range(0, 3), $urandom_range(0, 255));
        end else if (kind == 1) begin
          send_request(1'b0, $urandom_range(0, eff_height() - 1),
                       $urandom_range(0, eff_width() - 1), $urandom_range(0, eff_chans() - 1),
                       $urandom_range(0, 255));
        end else begin
          query_or_write($urandom_range(0, eff_height() - 1), $urandom_range(0, eff_width() - 1),
                         $urandom_range(0, eff_chans() - 1));
        end
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      n_medians++;
      if (pending_medians.size() == 0) begin
        $display("%0t: unexpected median: row %0d col %0d chan %0d median %0d", $time,
                 out_row_o, out_col_o, out_chan_o, median_o);
        errors++;
      end else begin
        median_res_t e;
        e = pending_medians.pop_front();
        if (out_row_o !== e.row || out_col_o !== e.col || out_chan_o !== e.chan ||
            median_o !== e.median) begin
          $display("%0t: mismatch: expected row %0d col %0d chan %0d median %0d, got %0d %0d %0d %0d",
                   $time, e.row, e.col, e.chan, e.median,
                   out_row_o, out_col_o, out_chan_o, median_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= StallLimit) begin
      $display("%0t: no progress for %0d cycles", $time, StallLimit);
      $display("window_median_with_border_modes_unit_tb failed");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_special_cases();
    test_full_size_corners();
    test_random_images(1150);
    quiet = 1'b1;
    test_random_images(1300);
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_medians.size() != 0);
    repeat (150) @(posedge clk_i);
    $display("Covered %0d requests (%0d queries, %0d medians seen) over %0d register writes,",
             n_items, n_queries, n_medians, n_cfg);
    $display("all border modes, window sizes and clamped image shapes.");
    if (errors == 0 && pending_medians.size() == 0) begin
      $display("window_median_with_border_modes_unit_tb passed");
    end else begin
      $display("window_median_with_border_modes_unit_tb failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
